FILE: src/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared types and constants for the LRU page replacement block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lrupr_pkg;

    localparam int VIRTUAL_PAGES = 64;
    localparam int FRAMES        = 32;
    localparam int PAGE_W        = 6;
    localparam int FRAME_W       = 5;
    localparam int LIMIT_W       = 6;
    localparam int STAMP_W       = 32;
    localparam int FAULT_W       = 16;
    localparam int IDX_W         = $clog2(VIRTUAL_PAGES);

    localparam logic [LIMIT_W-1:0] FRAMES_IN_USE_RST = LIMIT_W'(28);
    localparam logic [STAMP_W-1:0] STAMP_MAX         = '1;
    localparam logic [FAULT_W-1:0] FAULT_MAX         = '1;

    localparam logic MODE_REF   = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [PAGE_W-1:0] page_number;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
        logic               evicted_valid;
        logic [PAGE_W-1:0]  evicted_page;
        logic [FAULT_W-1:0] fault_count;
    } rsp_t;

    // one page table entry in RAM
    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } mem_rd_t;

    typedef struct packed {
        logic             done;
        logic             found;
        logic [IDX_W-1:0] victim;
        logic [FRAME_W-1:0] frame;
    } scan_res_t;

endpackage

FILE: src/lrupr_if.sv
// ----------------------------------------------------------------------------
// lrupr_if
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lrupr_req_if
    import lrupr_pkg::*;
;
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lrupr_rsp_if
    import lrupr_pkg::*;
;
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/lrupr_ram.sv
// ----------------------------------------------------------------------------
// lrupr_ram
// Page table RAM: frame and timestamp per virtual page, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrupr_ram
    import lrupr_pkg::*;
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data,
    input  mem_rd_t          rd,
    output entry_t           rd_data
);

    entry_t mem [VIRTUAL_PAGES];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/lrupr_scan.sv
// ----------------------------------------------------------------------------
// lrupr_scan
// Victim search: walks the page table one entry per cycle and keeps the
// resident page with the smallest stamp, lowest page on ties.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrupr_scan
    import lrupr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [VIRTUAL_PAGES-1:0] resident,
    input  entry_t                   rd_data,
    output mem_rd_t                  rd,
    output scan_res_t                res
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VIRTUAL_PAGES - 1);

    logic               issuing_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               cmp_valid_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic               done_reg;
    logic               found_reg;
    logic [STAMP_W-1:0] best_reg;
    logic [IDX_W-1:0]   victim_reg;
    logic [FRAME_W-1:0] vframe_reg;
    logic               take;

    // strict compare keeps the lowest page among equal stamps
    assign take = cmp_valid_reg && resident[cmp_idx_reg]
                  && (!found_reg || (rd_data.stamp < best_reg));

    assign rd.en   = issuing_reg;
    assign rd.addr = idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issuing_reg   <= 1'b0;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
            done_reg      <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= issuing_reg;
            cmp_idx_reg   <= idx_reg;
            done_reg      <= cmp_valid_reg && (cmp_idx_reg == LAST_IDX);
            if (start)
            begin
                issuing_reg <= 1'b1;
                idx_reg     <= '0;
                found_reg   <= 1'b0;
            end
            else
            begin
                if (issuing_reg)
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        issuing_reg <= 1'b0;
                    end
                    idx_reg <= idx_reg + IDX_W'(1);
                end
                if (take)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_reg   <= rd_data.stamp;
            victim_reg <= cmp_idx_reg;
            vframe_reg <= rd_data.frame;
        end
    end

    assign res.done   = done_reg;
    assign res.found  = found_reg;
    assign res.victim = victim_reg;
    assign res.frame  = vframe_reg;

endmodule

FILE: src/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement
// LRU page replacement with per-page timestamps held in a page table RAM.
// Clear and fill miss go straight to ST_DONE, hit reads its entry in ST_READ,
// eviction miss waits in ST_SCAN for the victim scan reading one entry per cycle.
// One transaction at a time; a finished response may wait in the output
// register while the next request is taken.
// Reset: resident bits, counters and frame limit (28) reset at once; the
// table RAM needs no clearing since only resident entries are used.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_page_replacement
    import lrupr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [LIMIT_W-1:0] cfg_wr_data,
    lrupr_req_if.sink          req,
    lrupr_rsp_if.source        rsp
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    typedef enum logic [1:0] {
        K_CLEAR = 2'd0,
        K_HIT   = 2'd1,
        K_FILL  = 2'd2,
        K_EVICT = 2'd3
    } kind_t;

    state_t                   state_reg, state_next;
    kind_t                    kind_reg;
    logic [VIRTUAL_PAGES-1:0] resident_reg;
    logic [LIMIT_W-1:0]       frames_taken_reg;
    logic [STAMP_W-1:0]       access_time_reg;
    logic [FAULT_W-1:0]       faults_reg;
    logic [LIMIT_W-1:0]       frames_in_use_reg;
    logic [IDX_W-1:0]         page_reg;
    logic [FRAME_W-1:0]       frame_reg;
    logic                     ev_valid_reg;
    logic [IDX_W-1:0]         ev_page_reg;
    logic                     rsp_valid_reg;
    rsp_t                     rsp_data_reg;

    logic               accept;
    logic               finish;
    logic [IDX_W-1:0]   req_page;
    logic [LIMIT_W-1:0] limit;
    logic [FAULT_W-1:0] faults_inc;
    logic [STAMP_W-1:0] time_inc;
    logic               hit_rd;
    logic               scan_start;
    mem_rd_t            scan_rd;
    mem_rd_t            mem_rd;
    scan_res_t          scan_res;
    entry_t             rd_data;
    entry_t             wr_data;
    logic               wr_en;

    assign req_page   = req.data.page_number[IDX_W-1:0];
    assign req.ready  = (state_reg == ST_IDLE);
    assign accept     = req.valid && req.ready;
    assign finish     = (state_reg == ST_DONE) && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        if (frames_in_use_reg == '0)
        begin
            limit = LIMIT_W'(1);
        end
        else if (frames_in_use_reg > LIMIT_W'(FRAMES))
        begin
            limit = LIMIT_W'(FRAMES);
        end
        else
        begin
            limit = frames_in_use_reg;
        end
    end

    assign faults_inc = (faults_reg != FAULT_MAX) ? faults_reg + FAULT_W'(1) : faults_reg;
    assign time_inc   = (access_time_reg != STAMP_MAX) ? access_time_reg + STAMP_W'(1)
                                                       : access_time_reg;

    assign hit_rd     = accept && (req.data.mode == MODE_REF) && resident_reg[req_page];
    assign scan_start = accept && (req.data.mode == MODE_REF) && !resident_reg[req_page]
                        && (frames_taken_reg >= limit);

    always_comb
    begin
        mem_rd = scan_rd;
        if (hit_rd)
        begin
            mem_rd.en   = 1'b1;
            mem_rd.addr = req_page;
        end
    end

    assign wr_en         = finish && (kind_reg != K_CLEAR);
    assign wr_data.frame = frame_reg;
    assign wr_data.stamp = access_time_reg;

    lrupr_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (page_reg),
        .wr_data (wr_data),
        .rd      (mem_rd),
        .rd_data (rd_data)
    );

    lrupr_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (scan_start),
        .resident (resident_reg),
        .rd_data  (rd_data),
        .rd       (scan_rd),
        .res      (scan_res)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (hit_rd)
                    begin
                        state_next = ST_READ;
                    end
                    else if (scan_start)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_READ: state_next = ST_DONE;
            ST_SCAN:
            begin
                if (scan_res.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            kind_reg          <= K_CLEAR;
            resident_reg      <= '0;
            frames_taken_reg  <= '0;
            access_time_reg   <= STAMP_W'(1);
            faults_reg        <= '0;
            frames_in_use_reg <= FRAMES_IN_USE_RST;
            rsp_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                frames_in_use_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                if (req.data.mode == MODE_CLEAR)
                begin
                    kind_reg <= K_CLEAR;
                end
                else if (hit_rd)
                begin
                    kind_reg <= K_HIT;
                end
                else if (scan_start)
                begin
                    kind_reg <= K_EVICT;
                end
                else
                begin
                    kind_reg <= K_FILL;
                end
            end
            if (finish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (finish)
            begin
                case (kind_reg)
                    K_CLEAR:
                    begin
                        resident_reg     <= '0;
                        frames_taken_reg <= '0;
                        access_time_reg  <= STAMP_W'(1);
                        faults_reg       <= '0;
                    end
                    K_HIT:
                    begin
                        access_time_reg <= time_inc;
                    end
                    K_FILL:
                    begin
                        resident_reg[page_reg] <= 1'b1;
                        frames_taken_reg       <= frames_taken_reg + LIMIT_W'(1);
                        access_time_reg        <= time_inc;
                        faults_reg             <= faults_inc;
                    end
                    K_EVICT:
                    begin
                        // victim never equals the faulting page, which is not resident
                        if (ev_valid_reg)
                        begin
                            resident_reg[ev_page_reg] <= 1'b0;
                        end
                        resident_reg[page_reg] <= 1'b1;
                        access_time_reg        <= time_inc;
                        faults_reg             <= faults_inc;
                    end
                    default:
                    begin
                        access_time_reg <= access_time_reg;
                    end
                endcase
            end
        end
    end

    // transaction payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_reg     <= req_page;
            frame_reg    <= frames_taken_reg[FRAME_W-1:0];
            ev_valid_reg <= 1'b0;
            ev_page_reg  <= '0;
        end
        if (state_reg == ST_READ)
        begin
            frame_reg <= rd_data.frame;
        end
        if ((state_reg == ST_SCAN) && scan_res.done)
        begin
            frame_reg    <= scan_res.found ? scan_res.frame : '0;
            ev_valid_reg <= scan_res.found;
            ev_page_reg  <= scan_res.found ? scan_res.victim : '0;
        end
        if (finish)
        begin
            if (kind_reg == K_CLEAR)
            begin
                rsp_data_reg <= '0;
            end
            else
            begin
                rsp_data_reg.hit           <= (kind_reg == K_HIT);
                rsp_data_reg.frame         <= frame_reg;
                rsp_data_reg.evicted_valid <= ev_valid_reg;
                rsp_data_reg.evicted_page  <= PAGE_W'(ev_page_reg);
                rsp_data_reg.fault_count   <= (kind_reg == K_HIT) ? faults_reg : faults_inc;
            end
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // every taken frame belongs to exactly one resident page
    a_resident_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(resident_reg) == int'(frames_taken_reg))
        else $error("resident page count differs from frames taken");

    a_taken_bound: assert property (@(posedge clk) disable iff (!rst_n)
        frames_taken_reg <= LIMIT_W'(FRAMES))
        else $error("frames taken beyond frame count");

    a_time_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        access_time_reg != '0)
        else $error("access time reached zero");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(rsp_data_reg.hit && rsp_data_reg.evicted_valid))
        else $error("hit reported with an eviction");

    a_scan_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        scan_start |-> (frames_taken_reg != '0))
        else $error("victim search with no resident page");

endmodule
